@@ hdl/kdtl_pkg.sv @@
package kdtl_pkg;

  localparam int NUM_KEYS   = 9;
  localparam int COUNT_BITS = 8;
  localparam int THR_W      = 8;
  localparam int CMP_W      = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int NUM_MODES  = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int MODE_RUN   = 0;
  localparam int MODE_STBY  = 1;
  localparam int MODE_NEG   = 2;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [THR_W-1:0]      thr_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [NUM_KEYS-1:0]   keys_t;
  typedef logic [NUM_MODES-1:0]  modes_t;

  localparam thr_t THR_RESET  = thr_t'(20);
  localparam logic REG_THRESH = 1'b0;

  typedef struct packed {
    keys_t  clean_keys;
    modes_t mode;
    logic   led_run;
  } res_t;

endpackage

@@ hdl/key_debounce_with_toggle_latches_top.sv @@
// Each accepted item's result is registered in the output buffer.
// One item per cycle unless stalled; every key has its own counter lane.
// A two-entry output buffer keeps input accepted while one result waits.
// Synchronous active-low reset clears all counters, levels and latches.
// Reset also sets the stable threshold register to 20.
module key_debounce_with_toggle_latches_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kdtl_pkg::NUM_KEYS-1:0] in_raw_keys,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kdtl_pkg::NUM_KEYS-1:0] out_clean_keys,
  output logic                          out_run_on,
  output logic                          out_standby_on,
  output logic                          out_negpress_on,
  output logic                          out_led_run,
  output logic                          out_led_standby,
  output logic                          out_led_negpress,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdtl_pkg::ADDR_W-1:0]   paddr,
  input  logic [kdtl_pkg::DATA_W-1:0]   pwdata,
  output logic [kdtl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  kdtl_pkg::thr_t  thr_r;
  kdtl_pkg::keys_t db_nxt;
  kdtl_pkg::res_t  res;
  kdtl_pkg::res_t  out_res;
  logic            acc;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[kdtl_pkg::ADDR_W-1] == kdtl_pkg::REG_THRESH);
  assign prdata  = reg_sel ? kdtl_pkg::DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= kdtl_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_r <= pwdata[kdtl_pkg::THR_W-1:0];
    end
  end

  assign acc = in_valid & ~in_stall;

  for (genvar k = 0; k < kdtl_pkg::NUM_KEYS; k++) begin : g_lane
    kdtl_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .acc    (acc),
      .smp    (in_raw_keys[k]),
      .thr    (thr_r),
      .db_nxt (db_nxt[k])
    );
  end

  kdtl_toggle u_toggle (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .db_nxt (db_nxt),
    .res    (res)
  );

  kdtl_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_data  (res),
    .full     (in_stall),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (out_res)
  );

  assign out_clean_keys   = out_res.clean_keys;
  assign out_run_on       = out_res.mode[kdtl_pkg::MODE_RUN];
  assign out_standby_on   = out_res.mode[kdtl_pkg::MODE_STBY];
  assign out_negpress_on  = out_res.mode[kdtl_pkg::MODE_NEG];
  assign out_led_run      = out_res.led_run;
  assign out_led_standby  = out_res.mode[kdtl_pkg::MODE_STBY];
  assign out_led_negpress = out_res.mode[kdtl_pkg::MODE_NEG];

endmodule

@@ hdl/kdtl_lane.sv @@
module kdtl_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                smp,
  input  kdtl_pkg::thr_t      thr,
  output logic                db_nxt
);

  localparam kdtl_pkg::cnt_t CNT_MAX = '1;

  logic           prev_r;
  logic           db_r;
  kdtl_pkg::cnt_t cnt_r;
  kdtl_pkg::cnt_t cnt_inc;
  kdtl_pkg::cnt_t cnt_nxt;

  always_comb begin
    cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + kdtl_pkg::cnt_t'(1);
    if (smp != prev_r) begin
      cnt_nxt = '0;
      db_nxt  = 1'b0;
    end else begin
      cnt_nxt = cnt_inc;
      if (kdtl_pkg::cmp_t'(cnt_inc) >= kdtl_pkg::cmp_t'(thr)) begin
        db_nxt = smp;
      end else begin
        db_nxt = db_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      db_r   <= 1'b0;
      cnt_r  <= '0;
    end else if (acc) begin
      prev_r <= smp;
      db_r   <= db_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hdl/kdtl_toggle.sv @@
module kdtl_toggle (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  kdtl_pkg::keys_t     db_nxt,
  output kdtl_pkg::res_t      res
);

  kdtl_pkg::modes_t ps_r;
  kdtl_pkg::modes_t ps_nxt;
  kdtl_pkg::modes_t mode_r;
  kdtl_pkg::modes_t mode_nxt;
  kdtl_pkg::modes_t tog;

  always_comb begin
    for (int b = 0; b < kdtl_pkg::NUM_MODES; b++) begin
      tog[b]      = db_nxt[b] & ~ps_r[b];
      ps_nxt[b]   = db_nxt[b];
      mode_nxt[b] = mode_r[b] ^ tog[b];
    end
    res.clean_keys = db_nxt;
    res.mode       = mode_nxt;
    res.led_run    = mode_nxt[kdtl_pkg::MODE_RUN] | tog[kdtl_pkg::MODE_NEG];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= '0;
      mode_r <= '0;
    end else if (acc) begin
      ps_r   <= ps_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ hdl/kdtl_outbuf.sv @@
module kdtl_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  input  kdtl_pkg::res_t      wr_data,
  output logic                full,
  output logic                rd_valid,
  input  logic                rd_stall,
  output kdtl_pkg::res_t      rd_data
);

  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           skid_valid_r;
  logic           skid_valid_nxt;
  logic           load_out;
  logic           load_skid;
  logic           wr;
  kdtl_pkg::res_t out_r;
  kdtl_pkg::res_t out_nxt;
  kdtl_pkg::res_t skid_r;

  assign full     = skid_valid_r;
  assign rd_valid = out_valid_r;
  assign rd_data  = out_r;
  assign wr       = wr_valid & ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    out_nxt        = wr_data;
    if (!out_valid_r || !rd_stall) begin
      if (skid_valid_r) begin
        load_out       = 1'b1;
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        load_out      = wr;
        out_valid_nxt = wr;
      end
    end else if (wr) begin
      load_skid      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
    if (load_skid) begin
      skid_r <= wr_data;
    end
  end

endmodule

@@ hdl/kdtl_checker.sv @@
module kdtl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kdtl_pkg::NUM_KEYS-1:0] out_clean_keys,
  input logic                          out_standby_on,
  input logic                          out_negpress_on,
  input logic                          out_led_run,
  input logic                          out_led_standby,
  input logic                          out_led_negpress
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while no result is pending");

  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_standby == out_standby_on) &&
                  (out_led_negpress == out_negpress_on))
    else $error("mode LED disagrees with its latch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clean_keys) &&
                               $stable(out_led_run))
    else $error("stalled item changed");

endmodule

bind key_debounce_with_toggle_latches_top kdtl_checker u_kdtl_checker (.*);

@@ tb/sv/key_debounce_with_toggle_latches_top_tb.sv @@
module key_debounce_with_toggle_latches_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kdtl_pkg::ADDR_W-1:0] THRESH_ADDR =
    kdtl_pkg::ADDR_W'(4 * kdtl_pkg::REG_THRESH);
  localparam logic [kdtl_pkg::ADDR_W-1:0] SPARE_ADDR  =
    kdtl_pkg::ADDR_W'(4 * (kdtl_pkg::REG_THRESH + 1));

  typedef struct {
    kdtl_pkg::keys_t clean;
    logic            run;
    logic            stby;
    logic            neg;
    logic            led_run;
    logic            led_stby;
    logic            led_neg;
  } key_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  kdtl_pkg::keys_t               in_raw_keys;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  kdtl_pkg::keys_t               out_clean_keys;
  logic                          out_run_on;
  logic                          out_standby_on;
  logic                          out_negpress_on;
  logic                          out_led_run;
  logic                          out_led_standby;
  logic                          out_led_negpress;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [kdtl_pkg::ADDR_W-1:0]   paddr;
  logic [kdtl_pkg::DATA_W-1:0]   pwdata;
  logic [kdtl_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  key_result_t pending_results[$];
  int          fail_count = 0;
  bit          calm = 1'b0;

  kdtl_pkg::thr_t   thr_now;
  kdtl_pkg::keys_t  prior_keys;
  kdtl_pkg::keys_t  steady_keys;
  kdtl_pkg::cnt_t   run_len [kdtl_pkg::NUM_KEYS];
  kdtl_pkg::modes_t held_mask;
  kdtl_pkg::modes_t modes;

  key_debounce_with_toggle_latches_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_keys      (in_raw_keys),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clean_keys   (out_clean_keys),
    .out_run_on       (out_run_on),
    .out_standby_on   (out_standby_on),
    .out_negpress_on  (out_negpress_on),
    .out_led_run      (out_led_run),
    .out_led_standby  (out_led_standby),
    .out_led_negpress (out_led_negpress),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  function automatic void debouncer_reset();
    thr_now     = kdtl_pkg::THR_RESET;
    prior_keys  = '0;
    steady_keys = '0;
    held_mask   = '0;
    modes       = '0;
    for (int i = 0; i < kdtl_pkg::NUM_KEYS; i++) run_len[i] = '0;
  endfunction

  function automatic key_result_t debounce_tick(kdtl_pkg::keys_t raw);
    key_result_t r;
    logic neg_flipped;
    neg_flipped = 1'b0;
    for (int i = 0; i < kdtl_pkg::NUM_KEYS; i++) begin
      if (raw[i] != prior_keys[i]) begin
        steady_keys[i] = 1'b0;
        run_len[i]     = '0;
      end else begin
        if (run_len[i] != '1) run_len[i] = run_len[i] + 1'b1;
        if (run_len[i] >= thr_now) steady_keys[i] = raw[i];
      end
    end
    prior_keys = raw;
    for (int m = 0; m < kdtl_pkg::NUM_MODES; m++) begin
      if (steady_keys[m] && !held_mask[m]) begin
        held_mask[m] = 1'b1;
        modes[m]     = ~modes[m];
        if (m == kdtl_pkg::MODE_NEG) neg_flipped = 1'b1;
      end else if (!steady_keys[m]) begin
        held_mask[m] = 1'b0;
      end
    end
    r.clean    = steady_keys;
    r.run      = modes[kdtl_pkg::MODE_RUN];
    r.stby     = modes[kdtl_pkg::MODE_STBY];
    r.neg      = modes[kdtl_pkg::MODE_NEG];
    r.led_run  = modes[kdtl_pkg::MODE_RUN] | neg_flipped;
    r.led_stby = modes[kdtl_pkg::MODE_STBY];
    r.led_neg  = modes[kdtl_pkg::MODE_NEG];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    key_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none actual %h", $realtime, out_clean_keys);
      end else begin
        e = pending_results.pop_front();
        check_field("clean_keys", 16'(e.clean), 16'(out_clean_keys));
        check_field("run_on", 16'(e.run), 16'(out_run_on));
        check_field("standby_on", 16'(e.stby), 16'(out_standby_on));
        check_field("negpress_on", 16'(e.neg), 16'(out_negpress_on));
        check_field("led_run", 16'(e.led_run), 16'(out_led_run));
        check_field("led_standby", 16'(e.led_stby), 16'(out_led_standby));
        check_field("led_negpress", 16'(e.led_neg), 16'(out_led_negpress));
      end
    end
  end

  task automatic send_keys(input kdtl_pkg::keys_t k);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_raw_keys <= k;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(debounce_tick(k));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [kdtl_pkg::ADDR_W-1:0] addr,
                           input logic [kdtl_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THRESH_ADDR) thr_now = data[kdtl_pkg::THR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check_threshold();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THRESH_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("threshold readback", 16'(thr_now), 16'(prdata[kdtl_pkg::THR_W-1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_threshold(input kdtl_pkg::thr_t thr);
    wait_drained();
    apb_write(THRESH_ADDR, kdtl_pkg::DATA_W'(thr));
    apb_check_threshold();
  endtask

  task automatic test_register_access();
    apb_check_threshold();
    apb_write(SPARE_ADDR, kdtl_pkg::DATA_W'(8'h55));
    apb_check_threshold();
    set_threshold(kdtl_pkg::thr_t'(1));
  endtask

  task automatic test_directed_keys();
    kdtl_pkg::keys_t seq [18] = '{9'h1FF, 9'h1FF, 9'h000, 9'h000, 9'h001, 9'h001,
                                  9'h000, 9'h004, 9'h004, 9'h004, 9'h002, 9'h002,
                                  9'h155, 9'h155, 9'h0AA, 9'h0AA, 9'h100, 9'h100};
    foreach (seq[i]) send_keys(seq[i]);
    set_threshold(kdtl_pkg::thr_t'(0));
    send_keys(9'h007);
    send_keys(9'h007);
    send_keys(9'h000);
  endtask

  task automatic test_counter_saturation();
    set_threshold(kdtl_pkg::thr_t'(255));
    repeat (280) send_keys(9'h1FF);
    repeat (5) send_keys(9'h000);
  endtask

  task automatic test_random_phase(input kdtl_pkg::thr_t thr, input int n,
                                   input bit no_idle, input bit pause);
    int              sent;
    int              run;
    int              pick;
    bit              paused;
    kdtl_pkg::keys_t k;
    sent   = 0;
    paused = 1'b0;
    set_threshold(thr);
    calm = no_idle;
    while (sent < n) begin
      k    = kdtl_pkg::keys_t'($urandom_range(511));
      pick = $urandom_range(99);
      if (pick < 65) begin
        run = $urandom_range(int'(thr) + 4, int'(thr) > 0 ? int'(thr) : 1);
        repeat (run) send_keys(k);
        sent += run;
      end else if (pick < 90) begin
        run = $urandom_range(4, 1);
        repeat (run) send_keys(kdtl_pkg::keys_t'($urandom_range(511)));
        sent += run;
      end else begin
        run = (int'(thr) > 1) ? int'(thr) - 1 : 1;
        repeat (run) send_keys(k);
        sent += run;
      end
      if (pause && !paused && sent >= n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_raw_keys = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    debouncer_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_register_access();
    test_directed_keys();
    test_counter_saturation();
    test_random_phase(kdtl_pkg::thr_t'(1), 100, 1'b0, 1'b0);
    test_random_phase(kdtl_pkg::thr_t'(3), 100, 1'b0, 1'b1);
    test_random_phase(kdtl_pkg::thr_t'(6), 100, 1'b1, 1'b0);
    test_random_phase(kdtl_pkg::thr_t'(2), 50, 1'b0, 1'b0);
    test_random_phase(kdtl_pkg::thr_t'($urandom_range(12, 1)), 50, 1'b0, 1'b0);
    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
